// ===== rtl/core/sorted_duplicate_key_index_macros.svh =====
`ifndef SORTED_DUPLICATE_KEY_INDEX_MACROS_SVH
`define SORTED_DUPLICATE_KEY_INDEX_MACROS_SVH

// Property that must hold at every edge outside reset
`define SDKI_ASSERT(lbl, clk, rst_n, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (prop)) else $error(msg);

// Antecedent this cycle, consequent on the next edge
`define SDKI_ASSERT_NEXT(lbl, clk, rst_n, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) else $error(msg);

`endif

// ===== rtl/core/sdki_pkg.sv =====
package sdki_pkg;

  localparam int KEY_W    = 64;
  localparam int ID_W     = 32;
  localparam int MC_W     = 7;
  localparam int KEY_CHARS = 8;
  localparam int MAX_EMIT = 64;

  localparam logic [1:0] ACT_INSERT = 2'd0;
  localparam logic [1:0] ACT_LOOKUP = 2'd1;
  localparam logic [1:0] ACT_DELETE = 2'd2;
  localparam logic [1:0] ACT_NONE   = 2'd3;

  localparam logic [1:0] ST_OK        = 2'd0;
  localparam logic [1:0] ST_NOT_FOUND = 2'd1;
  localparam logic [1:0] ST_FULL      = 2'd2;

  typedef struct packed {
    logic [KEY_W-1:0] key;
    logic [ID_W-1:0]  rid;
    logic             ins_en;
    logic             del_en;
    logic             sel_load;
    logic             sel_shift;
  } cmd_t;

  // cell to right-hand neighbour
  typedef struct packed {
    logic [KEY_W-1:0] key;
    logic [ID_W-1:0]  id;
    logic             place;
    logic             seen;
    logic             eq;
    logic             sel;
  } link_t;

  // cell to left-hand neighbour
  typedef struct packed {
    logic [KEY_W-1:0] key;
    logic [ID_W-1:0]  id;
    logic             eq;
  } back_t;

  // keep the first KEY_CHARS characters, zero everything after a zero character
  function automatic logic [KEY_W-1:0] norm_key(input logic [KEY_W-1:0] k);
    logic [KEY_W-1:0] r;
    logic             stop;
    logic [7:0]       c;
    r    = '0;
    stop = 1'b0;
    for (int i = 0; i < 8; i++) begin
      c = k[56-8*i +: 8];
      if (i >= KEY_CHARS || c == 8'd0) begin
        stop = 1'b1;
      end
      if (!stop) begin
        r[56-8*i +: 8] = c;
      end
    end
    return r;
  endfunction

endpackage

// ===== rtl/core/sdki_cell.sv =====
module sdki_cell (
  input  logic           clk,
  input  logic           rst_n,
  input  logic           occ,
  input  sdki_pkg::cmd_t  cmd,
  input  sdki_pkg::link_t left_i,
  input  sdki_pkg::back_t right_i,
  output sdki_pkg::link_t link_o,
  output sdki_pkg::back_t back_o,
  output logic           head_o,
  output logic           tail_o,
  output logic [31:0]    id_o
);
  import sdki_pkg::*;

  logic [KEY_W-1:0] key_r;
  logic [ID_W-1:0]  id_r;
  logic             sel_r;
  logic             eq;
  logic             place;
  logic             match;
  logic             seen;

  assign eq    = occ && (key_r == cmd.key);
  assign place = !occ || (cmd.key < key_r);
  assign match = eq && (id_r == cmd.rid);
  assign seen  = left_i.seen | match;

  always_ff @(posedge clk) begin
    if (cmd.ins_en) begin
      if (left_i.place) begin
        key_r <= left_i.key;
        id_r  <= left_i.id;
      end else if (place) begin
        key_r <= cmd.key;
        id_r  <= cmd.rid;
      end
    end else if (cmd.del_en && seen) begin
      key_r <= right_i.key;
      id_r  <= right_i.id;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      sel_r <= 1'b0;
    end else if (cmd.sel_load) begin
      sel_r <= head_o;
    end else if (cmd.sel_shift) begin
      sel_r <= left_i.sel;
    end
  end

  assign head_o = eq && !left_i.eq;
  assign tail_o = eq && !right_i.eq;
  assign id_o   = sel_r ? id_r : '0;

  assign link_o = '{key: key_r, id: id_r, place: place, seen: seen, eq: eq, sel: sel_r};
  assign back_o = '{key: key_r, id: id_r, eq: eq};

endmodule

// ===== rtl/core/sdki_gather.sv =====
module sdki_gather #(
  parameter int N  = 64,
  parameter int IW = 6
) (
  input  logic [N-1:0]  head,
  input  logic [N-1:0]  tail,
  input  logic [31:0]   idm [N],
  output logic [IW-1:0] head_idx,
  output logic [IW-1:0] tail_idx,
  output logic [31:0]   id
);

  always_comb begin
    head_idx = '0;
    tail_idx = '0;
    id       = '0;
    for (int i = 0; i < N; i++) begin
      head_idx = head_idx | (head[i] ? IW'(i) : '0);
      tail_idx = tail_idx | (tail[i] ? IW'(i) : '0);
      id       = id | idm[i];
    end
  end

endmodule

// ===== rtl/core/sorted_duplicate_key_index.sv =====
// Channel | Direction | Handshake             | Payload
// in_     | slave     | in_tvalid/in_tready   | in_tdata: action, key, record_id
// out_    | master    | out_tvalid/out_tready | out_tdata: status, found_id, match_count; out_tlast
// One item at a time: accept, then an execute state in which every cell compares and,
// for insert or delete, shifts in parallel (insert and delete finish here).
// A lookup hit then emits one id per cycle, up to 64 ids, a one-hot select token walking
// the cell row. Output stalls hold the block in place.
// Reset (synchronous, active low) empties the table; no clearing pass.
module sorted_duplicate_key_index #(
  parameter int CAPACITY = 64
) (
  input  logic         clk,
  input  logic         rst_n,
  input  logic         in_tvalid,
  output logic         in_tready,
  input  logic [103:0] in_tdata,   // action[1:0], key[65:2], record_id[97:66], zero pad
  output logic         out_tvalid,
  input  logic         out_tready,
  output logic [47:0]  out_tdata,  // status[1:0], found_id[33:2], match_count[40:34], zero pad
  output logic         out_tlast
);
  import sdki_pkg::*;

  `include "sorted_duplicate_key_index_macros.svh"

  localparam int CNT_W = $clog2(CAPACITY + 1);
  localparam int IDX_W = $clog2(CAPACITY);

  localparam logic [1:0] S_IDLE = 2'd0;
  localparam logic [1:0] S_EXEC = 2'd1;
  localparam logic [1:0] S_EMIT = 2'd2;

  logic [1:0]       state_r, state_nxt;
  logic [CNT_W-1:0] count_r, count_nxt;
  logic [1:0]       act_r;
  logic [KEY_W-1:0] key_r;
  logic [ID_W-1:0]  rid_r;
  logic [MC_W-1:0]  mc_r, mc_nxt;
  logic [MC_W-1:0]  rem_r, rem_nxt;

  logic             out_valid_r, out_valid_nxt;
  logic [1:0]       out_status_r, out_status_nxt;
  logic [ID_W-1:0]  out_id_r, out_id_nxt;
  logic [MC_W-1:0]  out_mc_r, out_mc_nxt;
  logic             out_last_r, out_last_nxt;

  cmd_t             cmd;
  link_t            link_w [CAPACITY+1];
  back_t            back_w [CAPACITY+1];
  logic [CAPACITY-1:0] head_v;
  logic [CAPACITY-1:0] tail_v;
  logic [31:0]      idm [CAPACITY];
  logic [CAPACITY-1:0] sel_v;
  logic [IDX_W-1:0] head_idx, tail_idx;
  logic [31:0]      gid;

  logic             in_acc;
  logic             out_free;
  logic             full;
  logic             hit;
  logic [CNT_W-1:0] cnt;
  logic [31:0]      cnt32;

  assign in_tready = (state_r == S_IDLE);
  assign in_acc    = in_tvalid && in_tready;
  assign out_free  = !out_valid_r || out_tready;
  assign full      = (count_r == CNT_W'(CAPACITY));
  assign hit       = |head_v;
  assign cnt       = CNT_W'(tail_idx) - CNT_W'(head_idx) + CNT_W'(1);
  assign cnt32     = 32'(cnt);

  assign link_w[0]        = '0;
  assign back_w[CAPACITY] = '0;

  for (genvar g = 0; g < CAPACITY; g++) begin : g_cell
    sdki_cell u_cell (
      .clk     (clk),
      .rst_n   (rst_n),
      .occ     (count_r > CNT_W'(g)),
      .cmd     (cmd),
      .left_i  (link_w[g]),
      .right_i (back_w[g+1]),
      .link_o  (link_w[g+1]),
      .back_o  (back_w[g]),
      .head_o  (head_v[g]),
      .tail_o  (tail_v[g]),
      .id_o    (idm[g])
    );
    assign sel_v[g] = link_w[g+1].sel;
  end

  sdki_gather #(
    .N  (CAPACITY),
    .IW (IDX_W)
  ) u_gather (
    .head     (head_v),
    .tail     (tail_v),
    .idm      (idm),
    .head_idx (head_idx),
    .tail_idx (tail_idx),
    .id       (gid)
  );

  always_comb begin
    state_nxt      = state_r;
    count_nxt      = count_r;
    mc_nxt         = mc_r;
    rem_nxt        = rem_r;
    out_valid_nxt  = out_valid_r && !out_tready;
    out_status_nxt = out_status_r;
    out_id_nxt     = out_id_r;
    out_mc_nxt     = out_mc_r;
    out_last_nxt   = out_last_r;
    cmd            = '{key: key_r, rid: rid_r, ins_en: 1'b0, del_en: 1'b0,
                       sel_load: 1'b0, sel_shift: 1'b0};
    unique case (state_r)
      S_IDLE: begin
        if (in_acc && in_tdata[1:0] != ACT_NONE) begin
          state_nxt = S_EXEC;
        end
      end
      S_EXEC: begin
        if (out_free) begin
          out_valid_nxt  = 1'b1;
          out_status_nxt = ST_OK;
          out_id_nxt     = '0;
          out_mc_nxt     = '0;
          out_last_nxt   = 1'b1;
          state_nxt      = S_IDLE;
          unique case (act_r)
            ACT_INSERT: begin
              if (full) begin
                out_status_nxt = ST_FULL;
              end else begin
                cmd.ins_en = 1'b1;
                count_nxt  = count_r + CNT_W'(1);
              end
            end
            ACT_DELETE: begin
              cmd.del_en = 1'b1;
              if (link_w[CAPACITY].seen) begin
                count_nxt = count_r - CNT_W'(1);
              end else begin
                out_status_nxt = ST_NOT_FOUND;
              end
            end
            ACT_LOOKUP: begin
              if (hit) begin
                out_valid_nxt = 1'b0;
                cmd.sel_load  = 1'b1;
                mc_nxt        = cnt32[MC_W-1:0];
                rem_nxt       = (cnt32 > 32'(MAX_EMIT)) ? MC_W'(MAX_EMIT) : cnt32[MC_W-1:0];
                state_nxt     = S_EMIT;
              end else begin
                out_status_nxt = ST_NOT_FOUND;
              end
            end
            default: begin
              out_valid_nxt = 1'b0;
            end
          endcase
        end
      end
      S_EMIT: begin
        if (out_free) begin
          out_valid_nxt  = 1'b1;
          out_status_nxt = ST_OK;
          out_id_nxt     = gid;
          out_mc_nxt     = mc_r;
          out_last_nxt   = (rem_r == MC_W'(1));
          cmd.sel_shift  = 1'b1;
          rem_nxt        = rem_r - MC_W'(1);
          if (rem_r == MC_W'(1)) begin
            state_nxt = S_IDLE;
          end
        end
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      count_r     <= '0;
      out_valid_r <= 1'b0;
      rem_r       <= '0;
    end else begin
      state_r     <= state_nxt;
      count_r     <= count_nxt;
      out_valid_r <= out_valid_nxt;
      rem_r       <= rem_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (in_acc) begin
      act_r <= in_tdata[1:0];
      key_r <= norm_key(in_tdata[65:2]);
      rid_r <= in_tdata[97:66];
    end
    mc_r         <= mc_nxt;
    out_status_r <= out_status_nxt;
    out_id_r     <= out_id_nxt;
    out_mc_r     <= out_mc_nxt;
    out_last_r   <= out_last_nxt;
  end

  assign out_tvalid = out_valid_r;
  assign out_tlast  = out_last_r;
  assign out_tdata  = {7'd0, out_mc_r, out_id_r, out_status_r};

  `SDKI_ASSERT(a_count_cap, clk, rst_n, count_r <= CNT_W'(CAPACITY), "entry count above capacity")
  `SDKI_ASSERT(a_emit_token, clk, rst_n, (state_r != S_EMIT) || $onehot(sel_v), "select token lost")
  `SDKI_ASSERT(a_emit_rem, clk, rst_n, (state_r != S_EMIT) || (rem_r != '0), "emit with nothing left")
  `SDKI_ASSERT_NEXT(a_count_step, clk, rst_n, state_r != S_EXEC, $stable(count_r), "count moved outside execute")

endmodule

// ===== bench/testbench.sv =====
module testbench;
  timeunit 1ns;
  timeprecision 1ps;

  import sdki_pkg::*;

  localparam int DEPTH       = 64;
  localparam int QUIET_LIMIT = 1000;
  localparam int MODE_MIX    = 0;
  localparam int MODE_FILL   = 1;
  localparam int MODE_DRAIN  = 2;

  typedef struct packed {
    logic [1:0]      status;
    logic [ID_W-1:0] found_id;
    logic [MC_W-1:0] match_count;
    logic            last;
  } reply_t;

  class key_index_tracker;
    logic [KEY_W-1:0] keys [DEPTH];
    logic [ID_W-1:0]  ids  [DEPTH];
    int               fill;
    reply_t           pending_replies [$];
    int mismatches, replies, inserts, rejects, hits, misses, removals, widest;

    function new();
      fill       = 0;
      mismatches = 0;
      replies    = 0;
      inserts    = 0;
      rejects    = 0;
      hits       = 0;
      misses     = 0;
      removals   = 0;
      widest     = 0;
    endfunction

    // first KEY_CHARS characters, nothing after a zero character
    function logic [KEY_W-1:0] trim_key(logic [KEY_W-1:0] raw);
      logic [KEY_W-1:0] r;
      logic [7:0]       c;
      logic             stop;
      r    = '0;
      stop = 1'b0;
      for (int i = 0; i < 8; i++) begin
        c = raw[KEY_W-8-8*i +: 8];
        if (i >= KEY_CHARS || c == 8'd0) stop = 1'b1;
        if (!stop) r[KEY_W-8-8*i +: 8] = c;
      end
      return r;
    endfunction

    function void push(logic [1:0] st, logic [ID_W-1:0] id, logic [MC_W-1:0] mc,
                       logic last);
      reply_t r;
      r.status      = st;
      r.found_id    = id;
      r.match_count = mc;
      r.last        = last;
      pending_replies.push_back(r);
    endfunction

    function void note_request(logic [1:0] act, logic [KEY_W-1:0] raw,
                               logic [ID_W-1:0] rid);
      logic [KEY_W-1:0] k;
      int pos, first, cnt, emit;
      k = trim_key(raw);
      case (act)
        ACT_INSERT: begin
          if (fill >= DEPTH) begin
            rejects++;
            push(ST_FULL, '0, '0, 1'b1);
          end else begin
            pos = fill;
            for (int i = fill - 1; i >= 0; i--) if (k < keys[i]) pos = i;
            for (int i = fill; i > pos; i--) begin
              keys[i] = keys[i-1];
              ids[i]  = ids[i-1];
            end
            keys[pos] = k;
            ids[pos]  = rid;
            fill++;
            inserts++;
            push(ST_OK, '0, '0, 1'b1);
          end
        end
        ACT_LOOKUP: begin
          first = 0;
          cnt   = 0;
          for (int i = 0; i < fill; i++) begin
            if (keys[i] == k) begin
              if (cnt == 0) first = i;
              cnt++;
            end
          end
          if (cnt == 0) begin
            misses++;
            push(ST_NOT_FOUND, '0, '0, 1'b1);
          end else begin
            hits++;
            if (cnt > widest) widest = cnt;
            emit = (cnt < MAX_EMIT) ? cnt : MAX_EMIT;
            for (int i = 0; i < emit; i++)
              push(ST_OK, ids[first+i], MC_W'(cnt), i == emit - 1);
          end
        end
        ACT_DELETE: begin
          pos = -1;
          for (int i = fill - 1; i >= 0; i--) if (keys[i] == k && ids[i] == rid) pos = i;
          if (pos < 0) begin
            push(ST_NOT_FOUND, '0, '0, 1'b1);
          end else begin
            for (int j = pos; j < fill - 1; j++) begin
              keys[j] = keys[j+1];
              ids[j]  = ids[j+1];
            end
            fill--;
            removals++;
            push(ST_OK, '0, '0, 1'b1);
          end
        end
        default: ;
      endcase
    endfunction

    function void check_reply(logic [47:0] data, logic tlast);
      reply_t got, want;
      got.status      = data[1:0];
      got.found_id    = data[33:2];
      got.match_count = data[40:34];
      got.last        = tlast;
      replies++;
      if (pending_replies.size() == 0) begin
        mismatches++;
        if (mismatches <= 10)
          $display("%0t: unexpected result status %0d id %h count %0d last %b", $time,
                   got.status, got.found_id, got.match_count, got.last);
        return;
      end
      want = pending_replies.pop_front();
      if (got.status !== want.status || got.found_id !== want.found_id ||
          got.match_count !== want.match_count || got.last !== want.last) begin
        mismatches++;
        if (mismatches <= 10)
          $display("%0t: result %0d exp/got status %0d/%0d id %h/%h count %0d/%0d last %b/%b",
                   $time, replies, want.status, got.status, want.found_id, got.found_id,
                   want.match_count, got.match_count, want.last, got.last);
      end
    endfunction

    function int pending();
      return pending_replies.size();
    endfunction
  endclass

  logic         clk;
  logic         rst_n;
  logic         in_tvalid;
  logic         in_tready;
  logic [103:0] in_tdata;   // action[1:0], key[65:2], record_id[97:66], zero pad
  logic         out_tvalid;
  logic         out_tready;
  logic [47:0]  out_tdata;  // status[1:0], found_id[33:2], match_count[40:34], zero pad
  logic         out_tlast;

  key_index_tracker sb = new();
  logic [KEY_W-1:0] key_pool [8];
  int burst_left = 0;

  sorted_duplicate_key_index #(
    .CAPACITY(DEPTH)
  ) u_top (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_tvalid (in_tvalid),
    .in_tready (in_tready),
    .in_tdata  (in_tdata),
    .out_tvalid(out_tvalid),
    .out_tready(out_tready),
    .out_tdata (out_tdata),
    .out_tlast (out_tlast)
  );

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  // called at a falling edge, returns at the falling edge after the transfer
  task automatic send_item(input logic [1:0] act, input logic [KEY_W-1:0] key,
                           input logic [ID_W-1:0] rid);
    int gap;
    if (burst_left == 0) begin
      gap = ($urandom_range(0, 4) == 0) ? 0 : $urandom_range(1, 8);
      if (gap > 0) begin
        in_tvalid <= 1'b0;
        repeat (gap) @(negedge clk);
      end
      burst_left = $urandom_range(1, 12);
    end
    in_tvalid <= 1'b1;
    in_tdata  <= {6'b0, rid, key, act};
    do @(posedge clk); while (!in_tready);
    sb.note_request(act, key, rid);
    burst_left--;
    @(negedge clk);
  endtask

  task automatic random_item(input int mode);
    int p, n, idx, ins_pct, look_pct;
    logic [1:0]       act;
    logic [KEY_W-1:0] key;
    logic [ID_W-1:0]  rid;
    ins_pct  = (mode == MODE_FILL) ? 70 : (mode == MODE_DRAIN) ? 8 : 40;
    look_pct = (mode == MODE_FILL) ? 15 : (mode == MODE_DRAIN) ? 20 : 30;
    p   = $urandom_range(0, 99);
    key = key_pool[$urandom_range(0, 7)];
    rid = $urandom;
    if (p < 4) begin
      act = ACT_NONE;
      key = {$urandom, $urandom};
    end else if (p < 4 + ins_pct) begin
      act = ACT_INSERT;
      if (mode == MODE_FILL) key = key_pool[0];
      else if ($urandom_range(0, 9) == 0) key = {$urandom, $urandom};
      n = $urandom_range(0, 19);
      if (n < 3 && sb.fill > 0) rid = sb.ids[$urandom_range(0, sb.fill - 1)];
      else if (n == 3) rid = '0;
      else if (n == 4) rid = '1;
    end else if (p < 4 + ins_pct + look_pct) begin
      act = ACT_LOOKUP;
      if (sb.fill > 0 && $urandom_range(0, 9) < 7) key = sb.keys[$urandom_range(0, sb.fill - 1)];
    end else begin
      act = ACT_DELETE;
      n   = $urandom_range(0, 19);
      if (sb.fill > 0 && n < 14) begin
        idx = $urandom_range(0, sb.fill - 1);
        key = sb.keys[idx];
        if (n < 12) rid = sb.ids[idx];
      end
    end
    send_item(act, key, rid);
  endtask

  // receiver: ready, random, mostly stalled, or a long stall then ready
  initial begin
    int mode, len;
    out_tready = 1'b0;
    forever begin
      mode = $urandom_range(0, 3);
      len  = $urandom_range(8, 60);
      for (int c = 0; c < len; c++) begin
        @(negedge clk);
        case (mode)
          0:       out_tready <= 1'b1;
          1:       out_tready <= $urandom_range(0, 1);
          2:       out_tready <= ($urandom_range(0, 3) == 0);
          default: out_tready <= (c >= len / 2);
        endcase
      end
    end
  end

  always @(posedge clk) begin
    if (rst_n && out_tvalid && out_tready) sb.check_reply(out_tdata, out_tlast);
  end

  initial begin
    int quiet;
    quiet = 0;
    while (quiet < QUIET_LIMIT) begin
      @(posedge clk);
      if ((in_tvalid && in_tready) || (out_tvalid && out_tready)) quiet = 0;
      else quiet++;
    end
    $display("no transfer for %0d cycles, %0d results outstanding", QUIET_LIMIT, sb.pending());
    $display("Test completed with failures");
    $finish;
  end

  initial begin
    int guard, rejects_before;
    in_tvalid = 1'b0;
    in_tdata  = '0;
    rst_n     = 1'b0;
    for (int k = 0; k < 8; k++) key_pool[k] = {$urandom, $urandom};
    key_pool[5][31:24] = 8'h00;
    key_pool[6]        = key_pool[5];
    key_pool[6][23:0]  = $urandom;
    key_pool[7][63:56] = 8'h00;
    repeat (5) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;
    @(negedge clk);

    // directed: empty table, extremes, zero characters, duplicates, ignored action
    send_item(ACT_LOOKUP, 64'h0, 32'h0);
    send_item(ACT_DELETE, 64'h0, 32'h0);
    send_item(ACT_INSERT, 64'h0, 32'h0);
    send_item(ACT_INSERT, '1, '1);
    send_item(ACT_INSERT, 64'h4142_0058_595A_5B5C, 32'h5);
    send_item(ACT_LOOKUP, 64'h4142_0000_0000_0000, 32'h0);
    send_item(ACT_INSERT, 64'h4142_00FF_1122_3344, 32'h6);
    send_item(ACT_LOOKUP, 64'h4142_00FF_FFFF_FFFF, '1);
    send_item(ACT_LOOKUP, '1, 32'h0);
    send_item(ACT_NONE, 64'h4142_0000_0000_0000, 32'h5);
    send_item(ACT_DELETE, 64'h4142_0000_0000_0000, 32'h7);
    send_item(ACT_DELETE, 64'h4142_0000_0000_0000, 32'h5);
    send_item(ACT_LOOKUP, 64'h4142_0000_0000_0000, 32'h0);
    send_item(ACT_INSERT, 64'h00FF_EEDD_CCBB_AA99, 32'hA5A5_A5A5);
    send_item(ACT_LOOKUP, 64'h0, 32'h0);
    send_item(ACT_DELETE, 64'h0012_3456_789A_BCDE, 32'h0);
    send_item(ACT_DELETE, '1, '1);
    send_item(ACT_LOOKUP, '1, 32'h0);
    send_item(ACT_INSERT, 64'h8000_0000_0000_0000, 32'h1);
    send_item(ACT_INSERT, 64'h7FFF_FFFF_FFFF_FFFF, 32'h2);
    send_item(ACT_NONE, '1, '1);
    send_item(ACT_LOOKUP, 64'h8000_0000_0000_0000, 32'h0);

    for (int n = 0; n < 50; n++) random_item(MODE_MIX);
    guard = 0;
    while (sb.fill > 0 && guard < 150) begin
      random_item(MODE_DRAIN);
      guard++;
    end
    // one key to capacity, then inserts against a full table
    rejects_before = sb.rejects;
    guard          = 0;
    while (sb.rejects < rejects_before + 4 && guard < 250) begin
      random_item(MODE_FILL);
      guard++;
    end
    guard = 0;
    while (sb.fill > 0 && guard < 60) begin
      random_item(MODE_DRAIN);
      guard++;
    end
    in_tvalid <= 1'b0;

    while (sb.pending() != 0) @(posedge clk);
    repeat (20) @(posedge clk);

    $display("%0d inserts (%0d refused when full), %0d deletes, %0d lookup hits, %0d misses",
             sb.inserts, sb.rejects, sb.removals, sb.hits, sb.misses);
    $display("%0d results checked, longest duplicate run %0d, %0d mismatches",
             sb.replies, sb.widest, sb.mismatches);
    if (sb.mismatches == 0) begin
      $display("Test completed successfully");
    end else begin
      $display("Test completed with failures");
    end
    $finish;
  end

endmodule

// ===== filelist.f =====
+incdir+rtl/core
rtl/core/sdki_pkg.sv
rtl/core/sdki_cell.sv
rtl/core/sdki_gather.sv
rtl/core/sorted_duplicate_key_index.sv
bench/testbench.sv
